>>> src/gsp_pkg.sv
// Shared types, constants and neighbour tables for the grid path block.
package gsp_pkg;

  localparam int POS_W  = 6;   // width of row and column fields of a request
  localparam int SIZE_W = 7;   // width of the grid size registers
  localparam int LEN_W  = 13;  // width of path_length
  localparam int NEXT_W = 7;   // width of next_row and next_col
  localparam int LEN_SAT = 4095;
  localparam int NBR_CNT = 8;
  localparam int NBR_W  = 3;
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_DIAG = 2'd2
  } reg_idx_t;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic              diag;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CHK_S,
    ST_CHK_G,
    ST_CHK_DONE,
    ST_VIS_CLR,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_CUR_WAIT,
    ST_NB_ISSUE,
    ST_NB_CHECK,
    ST_FIN_RD,
    ST_FIN_WAIT
  } state_t;

  // Row offset of neighbour k, row-major from (-1,-1) to (+1,+1) without the center.
  function automatic logic signed [1:0] nbr_dr(input logic [NBR_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nbr_dc(input logic [NBR_W-1:0] k);
    logic signed [1:0] d;
    case (k)
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

>>> src/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/gsp_cfg.sv
// APB configuration registers: grid size and diagonal enable.
module gsp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsp_pkg::APB_AW-1:0]  paddr,
  input  logic [gsp_pkg::APB_DW-1:0]  pwdata,
  output logic [gsp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output gsp_pkg::cfg_t               cfg
);
  import gsp_pkg::*;

  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= SIZE_W'(DEF_MAX_ROWS);
      cfg.cols <= SIZE_W'(DEF_MAX_COLS);
      cfg.diag <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_ROWS: cfg.rows <= pwdata[SIZE_W-1:0];
        REG_COLS: cfg.cols <= pwdata[SIZE_W-1:0];
        REG_DIAG: cfg.diag <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS: prdata = APB_DW'(cfg.rows);
      REG_COLS: prdata = APB_DW'(cfg.cols);
      REG_DIAG: prdata = APB_DW'(cfg.diag);
      default:  prdata = '0;
    endcase
  end

endmodule

>>> src/gsp_nbr.sv
// Neighbour k of a cell: coordinates and whether it lies inside the grid and move set.
module gsp_nbr #(
  parameter int ROW_W = 6,
  parameter int COL_W = 6,
  parameter int LIM_W = 7
) (
  input  logic [ROW_W-1:0]          base_row,
  input  logic [COL_W-1:0]          base_col,
  input  logic [gsp_pkg::NBR_W-1:0] k,
  input  logic [LIM_W-1:0]          row_lim,
  input  logic [LIM_W-1:0]          col_lim,
  input  logic                      diag,
  output logic                      ok,
  output logic [ROW_W-1:0]          nrow,
  output logic [COL_W-1:0]          ncol
);
  import gsp_pkg::*;

  logic signed [1:0]       dr, dc;
  logic signed [LIM_W+1:0] rr, cc;

  always_comb begin
    dr = nbr_dr(k);
    dc = nbr_dc(k);
    rr = $signed({2'b00, LIM_W'(base_row)}) + (LIM_W+2)'(dr);
    cc = $signed({2'b00, LIM_W'(base_col)}) + (LIM_W+2)'(dc);
    ok = (diag || dr == 2'sd0 || dc == 2'sd0)
         && rr >= 0 && cc >= 0
         && rr < $signed({2'b00, row_lim})
         && cc < $signed({2'b00, col_lim});
    nrow = rr[ROW_W-1:0];
    ncol = cc[COL_W-1:0];
  end

endmodule

>>> src/grid_shortest_path_next_step_core.sv
// Grid shortest-path core: obstacle map, breadth-first flood and first-step pick.
//
//   channel | direction | handshake              | payload
//   in      | request   | in_valid / in_stall    | command cell_row cell_col blocked goal_row goal_col
//   out     | result    | out_valid / out_stall  | found path_length next_row next_col
//   cfg     | APB       | psel penable pwrite    | paddr pwdata prdata pready
//
// A query checks the start and goal cells, then clears the visited marks over all
// 2**(clog2(MAX_ROWS) + clog2(MAX_COLS)) grid addresses, then floods outward from the
// goal, dequeuing cells and trying their neighbours in turn through the single read port
// of the node memory, and at the end picks the first step from the start cell.
// After reset the map and node memories are cleared, one address per cycle, for the
// same grid address count; no request is taken until then.
// A request is taken only while idle and with the result register free.
module grid_shortest_path_next_step_core #(
  parameter int MAX_ROWS = gsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gsp_pkg::DEF_MAX_COLS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gsp_pkg::APB_AW-1:0]        paddr,
  input  logic [gsp_pkg::APB_DW-1:0]        pwdata,
  output logic [gsp_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [gsp_pkg::POS_W-1:0]         cell_row,
  input  logic [gsp_pkg::POS_W-1:0]         cell_col,
  input  logic                              blocked,
  input  logic [gsp_pkg::POS_W-1:0]         goal_row,
  input  logic [gsp_pkg::POS_W-1:0]         goal_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              found,
  output logic signed [gsp_pkg::LEN_W-1:0]  path_length,
  output logic signed [gsp_pkg::NEXT_W-1:0] next_row,
  output logic signed [gsp_pkg::NEXT_W-1:0] next_col
);
  import gsp_pkg::*;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int AW    = ROW_W + COL_W;
  localparam int GRID_DEPTH = 1 << AW;
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int QW    = $clog2(CELLS);
  localparam int DMAX  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int LIM_W = ($clog2(DMAX + 1) > SIZE_W) ? $clog2(DMAX + 1) : SIZE_W;
  localparam int DW    = ($clog2(CELLS) + 1 > LEN_W) ? $clog2(CELLS) + 1 : LEN_W;

  cfg_t cfg;

  gsp_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Clamped grid limits
  logic [LIM_W-1:0] rows_ext, cols_ext, row_lim, col_lim;
  always_comb begin
    rows_ext = LIM_W'(cfg.rows);
    cols_ext = LIM_W'(cfg.cols);
    row_lim  = (rows_ext == '0) ? LIM_W'(1) :
               (rows_ext > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : rows_ext;
    col_lim  = (cols_ext == '0) ? LIM_W'(1) :
               (cols_ext > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS) : cols_ext;
  end

  // Memories
  logic          grid_we, grid_wdata, grid_rdata;
  logic [AW-1:0] grid_waddr, grid_raddr;
  logic          node_we;
  logic [AW-1:0] node_waddr, node_raddr;
  logic [DW:0]   node_wdata, node_rdata;
  logic          q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  logic [AW-1:0] q_wdata, q_rdata;

  gsp_ram #(.WIDTH(1), .DEPTH(GRID_DEPTH)) u_grid (
    .clk, .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_rdata)
  );

  gsp_ram #(.WIDTH(DW + 1), .DEPTH(GRID_DEPTH)) u_node (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  gsp_ram #(.WIDTH(AW), .DEPTH(CELLS)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Sequencer registers
  state_t            state, state_next;
  logic [AW-1:0]     sweep;
  logic [ROW_W-1:0]  sr, gr, cur_r, nb_r;
  logic [COL_W-1:0]  sc, gc, cur_c, nb_c;
  logic [DW-1:0]     cur_d, bestd;
  logic [QW:0]       head, tail;
  logic [NBR_W-1:0]  k;
  logic              start_vis, final_mode, blk_s;

  // Neighbour of the current base cell
  logic             nb_ok;
  logic [ROW_W-1:0] nb_row_c;
  logic [COL_W-1:0] nb_col_c;

  gsp_nbr #(.ROW_W(ROW_W), .COL_W(COL_W), .LIM_W(LIM_W)) u_nbr (
    .base_row(final_mode ? sr : cur_r),
    .base_col(final_mode ? sc : cur_c),
    .k,
    .row_lim,
    .col_lim,
    .diag(cfg.diag),
    .ok(nb_ok),
    .nrow(nb_row_c),
    .ncol(nb_col_c)
  );

  logic in_acc;
  logic in_range, wr_in_grid;
  logic nb_free, nb_vis;
  logic [DW-1:0] nb_d;

  assign in_stall = (state != ST_IDLE) | (out_valid & out_stall);
  assign in_acc   = in_valid & ~in_stall;
  assign in_range = (LIM_W'(cell_row) < row_lim) && (LIM_W'(cell_col) < col_lim)
                    && (LIM_W'(goal_row) < row_lim) && (LIM_W'(goal_col) < col_lim);
  assign wr_in_grid = (LIM_W'(cell_row) < LIM_W'(MAX_ROWS))
                      && (LIM_W'(cell_col) < LIM_W'(MAX_COLS));
  assign nb_free = ~grid_rdata;
  assign nb_vis  = node_rdata[DW];
  assign nb_d    = node_rdata[DW-1:0];

  // Result load
  logic              out_load, ld_found;
  logic [LEN_W-1:0]  ld_len;
  logic [NEXT_W-1:0] ld_row, ld_col;
  logic              k_last;

  assign k_last = (k == NBR_W'(NBR_CNT - 1));

  always_comb begin
    state_next = state;
    grid_we    = 1'b0;
    grid_waddr = {sr, sc};
    grid_wdata = 1'b0;
    grid_raddr = {sr, sc};
    node_we    = 1'b0;
    node_waddr = {nb_r, nb_c};
    node_wdata = {1'b1, cur_d + DW'(1)};
    node_raddr = {nb_row_c, nb_col_c};
    q_we       = 1'b0;
    q_waddr    = tail[QW-1:0];
    q_wdata    = {nb_r, nb_c};
    q_raddr    = head[QW-1:0];
    out_load   = 1'b0;
    ld_found   = 1'b0;
    ld_len     = '1;
    ld_row     = '1;
    ld_col     = '1;

    case (state)
      ST_INIT_CLR: begin
        grid_we    = 1'b1;
        grid_waddr = sweep;
        node_we    = 1'b1;
        node_waddr = sweep;
        node_wdata = '0;
        if (&sweep) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (command == CMD_WRITE) begin
            grid_we    = wr_in_grid;
            grid_waddr = {ROW_W'(cell_row), COL_W'(cell_col)};
            grid_wdata = blocked;
            out_load   = 1'b1;
            ld_len     = '0;
            ld_row     = '0;
            ld_col     = '0;
          end else if (!in_range) begin
            out_load = 1'b1;
          end else begin
            state_next = ST_CHK_S;
          end
        end
      end
      ST_CHK_S: begin
        grid_raddr = {sr, sc};
        state_next = ST_CHK_G;
      end
      ST_CHK_G: begin
        grid_raddr = {gr, gc};
        state_next = ST_CHK_DONE;
      end
      ST_CHK_DONE: begin
        if (blk_s || grid_rdata) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end else if (sr == gr && sc == gc) begin
          out_load   = 1'b1;
          ld_found   = 1'b1;
          ld_len     = '0;
          ld_row     = NEXT_W'(sr);
          ld_col     = NEXT_W'(sc);
          state_next = ST_IDLE;
        end else begin
          state_next = ST_VIS_CLR;
        end
      end
      ST_VIS_CLR: begin
        node_we    = 1'b1;
        node_waddr = sweep;
        node_wdata = '0;
        if (&sweep) state_next = ST_SEED;
      end
      ST_SEED: begin
        node_we    = 1'b1;
        node_waddr = {gr, gc};
        node_wdata = {1'b1, DW'(0)};
        q_we       = 1'b1;
        q_waddr    = '0;
        q_wdata    = {gr, gc};
        state_next = ST_POP;
      end
      ST_POP: begin
        if (start_vis) begin
          state_next = ST_FIN_RD;
        end else if (head < tail) begin
          q_raddr    = head[QW-1:0];
          state_next = ST_POP_WAIT;
        end else begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POP_WAIT: begin
        node_raddr = q_rdata;
        state_next = ST_CUR_WAIT;
      end
      ST_CUR_WAIT: begin
        state_next = ST_NB_ISSUE;
      end
      ST_NB_ISSUE: begin
        grid_raddr = {nb_row_c, nb_col_c};
        node_raddr = {nb_row_c, nb_col_c};
        if (nb_ok) begin
          state_next = ST_NB_CHECK;
        end else if (k_last) begin
          if (final_mode) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_POP;
          end
        end
      end
      ST_NB_CHECK: begin
        if (final_mode) begin
          if (nb_free && nb_vis && (nb_d + DW'(1) == bestd)) begin
            out_load   = 1'b1;
            ld_found   = 1'b1;
            ld_len     = (bestd > DW'(LEN_SAT)) ? LEN_W'(LEN_SAT) : bestd[LEN_W-1:0];
            ld_row     = NEXT_W'(nb_r);
            ld_col     = NEXT_W'(nb_c);
            state_next = ST_IDLE;
          end else if (k_last) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_NB_ISSUE;
          end
        end else begin
          if (nb_free && !nb_vis) begin
            node_we = 1'b1;
            q_we    = 1'b1;
          end
          state_next = k_last ? ST_POP : ST_NB_ISSUE;
        end
      end
      ST_FIN_RD: begin
        node_raddr = {sr, sc};
        state_next = ST_FIN_WAIT;
      end
      ST_FIN_WAIT: begin
        state_next = ST_NB_ISSUE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      head       <= '0;
      tail       <= '0;
      k          <= '0;
      start_vis  <= 1'b0;
      final_mode <= 1'b0;
    end else begin
      case (state)
        ST_INIT_CLR, ST_VIS_CLR: sweep <= sweep + AW'(1);
        ST_IDLE: begin
          if (in_acc) begin
            sr <= ROW_W'(cell_row);
            sc <= COL_W'(cell_col);
            gr <= ROW_W'(goal_row);
            gc <= COL_W'(goal_col);
          end
          final_mode <= 1'b0;
        end
        ST_CHK_G: blk_s <= grid_rdata;
        ST_SEED: begin
          head      <= '0;
          tail      <= (QW+1)'(1);
          start_vis <= 1'b0;
        end
        ST_POP: begin
          if (!start_vis && head < tail) head <= head + (QW+1)'(1);
        end
        ST_POP_WAIT: {cur_r, cur_c} <= q_rdata;
        ST_CUR_WAIT: begin
          cur_d      <= node_rdata[DW-1:0];
          k          <= '0;
          final_mode <= 1'b0;
        end
        ST_NB_ISSUE: begin
          nb_r <= nb_row_c;
          nb_c <= nb_col_c;
          if (!nb_ok) k <= k + NBR_W'(1);
        end
        ST_NB_CHECK: begin
          if (!final_mode && nb_free && !nb_vis) begin
            tail <= tail + (QW+1)'(1);
            // stop the flood once the start cell is reached
            if (nb_r == sr && nb_c == sc) start_vis <= 1'b1;
          end
          k <= k + NBR_W'(1);
        end
        ST_FIN_WAIT: begin
          bestd      <= node_rdata[DW-1:0];
          k          <= '0;
          final_mode <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found       <= ld_found;
      path_length <= ld_len;
      next_row    <= ld_row;
      next_col    <= ld_col;
    end
  end

endmodule
